// ----- hw/rtl/sdau_pkg.sv -----
package sdau_pkg;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CMP = 3'd4
    } op_t;

    // Clamp a nibble to a decimal digit: codes above nine count as nine.
    function automatic logic [3:0] clamp_digit(input logic [3:0] d);
        clamp_digit = (d > 4'd9) ? 4'd9 : d;
    endfunction

    // Add two BCD digits with carry in; returns {carry, digit}.
    function automatic logic [4:0] bcd_add_digit(input logic [3:0] x, input logic [3:0] y,
                                                 input logic c);
        logic [4:0] s;
        s = {1'b0, x} + {1'b0, y} + {4'd0, c};
        if (s > 5'd9)
            bcd_add_digit = {1'b1, 4'(s - 5'd10)};
        else
            bcd_add_digit = {1'b0, s[3:0]};
    endfunction

    // Subtract BCD digits with borrow in; returns {borrow, digit}.
    function automatic logic [4:0] bcd_sub_digit(input logic [3:0] x, input logic [3:0] y,
                                                 input logic b);
        logic [4:0] s;
        s = {1'b0, x} - {1'b0, y} - {4'd0, b};
        if (s[4])
            bcd_sub_digit = {1'b1, 4'(s + 5'd10)};
        else
            bcd_sub_digit = {1'b0, s[3:0]};
    endfunction

endpackage

// ----- hw/rtl/signed_decimal_arithmetic_unit.sv -----
// Channel  | Ports                                                | Handshake
// ---------+------------------------------------------------------+----------------------
// request  | req_type a_digits a_neg b_digits b_neg               | start & !busy
// result   | result_digits result_neg a_greater status            | done, one cycle
//
// All arithmetic runs through one BCD digit adder/subtractor, one digit per cycle.
// Add, subtract and compare make one or two passes over all 2N digits; multiply adds a shifted
// b into the accumulator once per unit of each multiplier digit of a;
// divide is restoring. The result is registered in S_FIN, and S_OUT returns to idle.
// N is NUM_DIGITS. Reset clears the sequencer; results cannot be stalled, done pulses
// for one cycle.
module signed_decimal_arithmetic_unit #(
    parameter int NUM_DIGITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [2:0]  req_type,
    input  logic [31:0] a_digits,
    input  logic        a_neg,
    input  logic [31:0] b_digits,
    input  logic        b_neg,
    output logic [63:0] result_digits,
    output logic        result_neg,
    output logic        a_greater,
    output logic        status
);
    localparam int ND = NUM_DIGITS;
    localparam int WD = 2 * ND;
    localparam int DW = $clog2(WD);
    localparam int NW = $clog2(ND + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CMP, S_ADD, S_MUL_ADD, S_MUL_NEXT, S_DIV_SUB, S_DIV_NEXT, S_FIN, S_OUT
    } state_t;

    state_t state_reg;
    logic [2:0]    op_reg;
    logic [4*WD-1:0] x_reg;    // operand A / remainder
    logic [4*WD-1:0] y_reg;    // operand B, shifted
    logic [4*WD-1:0] acc_reg;  // sum / product / quotient
    logic [4*WD-1:0] tmp_reg;  // digit-serial scratch result
    logic            na_reg, nb_reg, neg_reg, gt_reg, st_reg, cy_reg, sub_reg;
    logic [DW-1:0]   di_reg;
    logic [NW-1:0]   pos_reg;
    logic [3:0]      cnt_reg;

    logic [3:0] alu_x, alu_y, alu_d;
    logic       alu_cout;

    sdau_digit_alu u_alu (
        .x(alu_x), .y(alu_y), .cin(cy_reg), .sub(sub_reg), .d(alu_d), .cout(alu_cout)
    );

    logic [4*WD-1:0] a_in, b_in;
    logic a_zero, b_zero;

    always_comb
    begin
        a_in = '0;
        b_in = '0;
        for (int i = 0; i < ND; i++)
        begin
            a_in[4*i +: 4] = sdau_pkg::clamp_digit(a_digits[4*i +: 4]);
            b_in[4*i +: 4] = sdau_pkg::clamp_digit(b_digits[4*i +: 4]);
        end
        a_zero = (a_in == '0);
        b_zero = (b_in == '0);
    end

    // Operands of the digit step: for mul/div the accumulator or remainder pairs with y.
    logic [4*WD-1:0] lhs;
    always_comb
    begin
        if (state_reg == S_MUL_ADD)
            lhs = acc_reg;
        else
            lhs = x_reg;
        alu_x = lhs[4*di_reg +: 4];
        alu_y = y_reg[4*di_reg +: 4];
    end

    logic [4*WD-1:0] tmp_new;
    logic last_digit;
    always_comb
    begin
        tmp_new = tmp_reg;
        tmp_new[4*di_reg +: 4] = alu_d;
        last_digit = (di_reg == DW'(WD - 1));
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done          <= 1'b0;
            op_reg        <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            acc_reg       <= '0;
            tmp_reg       <= '0;
            na_reg        <= 1'b0;
            nb_reg        <= 1'b0;
            neg_reg       <= 1'b0;
            gt_reg        <= 1'b0;
            st_reg        <= 1'b0;
            cy_reg        <= 1'b0;
            sub_reg       <= 1'b0;
            di_reg        <= '0;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            result_digits <= '0;
            result_neg    <= 1'b0;
            a_greater     <= 1'b0;
            status        <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg  <= req_type;
                        x_reg   <= a_in;
                        y_reg   <= b_in;
                        acc_reg <= '0;
                        tmp_reg <= '0;
                        na_reg  <= a_neg & !a_zero;
                        nb_reg  <= (req_type == sdau_pkg::OP_SUB) ? (!b_neg & !b_zero)
                                                                   : (b_neg & !b_zero);
                        gt_reg  <= 1'b0;
                        st_reg  <= 1'b0;
                        cy_reg  <= 1'b0;
                        sub_reg <= 1'b1;
                        di_reg  <= '0;
                        pos_reg <= '0;
                        cnt_reg <= '0;
                        if (req_type == sdau_pkg::OP_DIV && b_zero)
                        begin
                            st_reg    <= 1'b1;
                            state_reg <= S_FIN;
                        end
                        else if (req_type == sdau_pkg::OP_MUL)
                        begin
                            sub_reg   <= 1'b0;
                            state_reg <= S_MUL_NEXT;
                        end
                        else if (req_type == sdau_pkg::OP_DIV)
                        begin
                            // Align divisor to the top of the quotient position.
                            y_reg     <= b_in << (4 * (ND - 1));
                            pos_reg   <= NW'(ND - 1);
                            state_reg <= S_DIV_SUB;
                        end
                        else if (req_type <= sdau_pkg::OP_SUB || req_type == sdau_pkg::OP_CMP)
                            state_reg <= S_CMP;
                        else
                            state_reg <= S_FIN;
                    end
                end
                // Trial subtract x - y to learn the magnitude order.
                S_CMP:
                begin
                    tmp_reg <= tmp_new;
                    cy_reg  <= alu_cout;
                    di_reg  <= di_reg + 1'b1;
                    if (last_digit)
                    begin
                        di_reg     <= '0;
                        cy_reg     <= 1'b0;
                        if (op_reg[2:0] == sdau_pkg::OP_CMP)
                        begin
                            if (na_reg != nb_reg)
                                gt_reg <= nb_reg;
                            else if (!na_reg)
                                gt_reg <= !alu_cout && (tmp_new != '0);
                            else
                                gt_reg <= alu_cout;
                            state_reg <= S_FIN;
                        end
                        else if (na_reg == nb_reg)
                        begin
                            sub_reg   <= 1'b0;
                            neg_reg   <= na_reg;
                            state_reg <= S_ADD;
                        end
                        else if (!alu_cout)
                        begin
                            acc_reg   <= tmp_new;
                            neg_reg   <= na_reg;
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            // b larger: compute b - a.
                            x_reg     <= y_reg;
                            y_reg     <= x_reg;
                            neg_reg   <= nb_reg;
                            state_reg <= S_ADD;
                        end
                    end
                end
                S_ADD:
                begin
                    tmp_reg <= tmp_new;
                    cy_reg  <= alu_cout;
                    di_reg  <= di_reg + 1'b1;
                    if (last_digit)
                    begin
                        acc_reg   <= tmp_new;
                        state_reg <= S_FIN;
                    end
                end
                // Take the next multiplier digit of a, shift b accordingly.
                S_MUL_NEXT:
                begin
                    if (pos_reg == NW'(ND))
                    begin
                        neg_reg   <= na_reg ^ nb_reg;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        cnt_reg   <= x_reg[4*pos_reg[NW-1:0] +: 4];
                        di_reg    <= '0;
                        cy_reg    <= 1'b0;
                        state_reg <= S_MUL_ADD;
                    end
                end
                S_MUL_ADD:
                begin
                    if (cnt_reg == 4'd0)
                    begin
                        y_reg     <= y_reg << 4;
                        pos_reg   <= pos_reg + 1'b1;
                        state_reg <= S_MUL_NEXT;
                    end
                    else
                    begin
                        tmp_reg <= tmp_new;
                        cy_reg  <= alu_cout;
                        di_reg  <= di_reg + 1'b1;
                        if (last_digit)
                        begin
                            acc_reg <= tmp_new;
                            cnt_reg <= cnt_reg - 1'b1;
                            di_reg  <= '0;
                            cy_reg  <= 1'b0;
                        end
                    end
                end
                // Restoring division: subtract shifted divisor while no borrow.
                S_DIV_SUB:
                begin
                    tmp_reg <= tmp_new;
                    cy_reg  <= alu_cout;
                    di_reg  <= di_reg + 1'b1;
                    if (last_digit)
                    begin
                        di_reg <= '0;
                        cy_reg <= 1'b0;
                        if (!alu_cout)
                        begin
                            x_reg   <= tmp_new;
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        else
                            state_reg <= S_DIV_NEXT;
                    end
                end
                S_DIV_NEXT:
                begin
                    acc_reg[4*pos_reg[NW-1:0] +: 4] <= cnt_reg;
                    cnt_reg <= '0;
                    y_reg   <= y_reg >> 4;
                    if (pos_reg == '0)
                    begin
                        neg_reg   <= na_reg ^ nb_reg;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        pos_reg   <= pos_reg - 1'b1;
                        state_reg <= S_DIV_SUB;
                    end
                end
                S_FIN:
                begin
                    result_digits <= 64'(acc_reg);
                    result_neg    <= neg_reg & (acc_reg != '0)
                                     & (op_reg[2:0] <= sdau_pkg::OP_DIV) & !st_reg;
                    a_greater     <= gt_reg;
                    status        <= st_reg;
                    done          <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                    state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- hw/rtl/sdau_digit_alu.sv -----
// Shared single-digit BCD unit: one add or subtract step on one digit pair.
module sdau_digit_alu (
    input  logic [3:0] x,
    input  logic [3:0] y,
    input  logic       cin,
    input  logic       sub,
    output logic [3:0] d,
    output logic       cout
);
    logic [4:0] r;

    always_comb
    begin
        if (sub)
            r = sdau_pkg::bcd_sub_digit(x, y, cin);
        else
            r = sdau_pkg::bcd_add_digit(x, y, cin);
        d    = r[3:0];
        cout = r[4];
    end
endmodule
